// ----- design/rba_pkg.sv -----
package rba_pkg;

    localparam int ARENA_MAX_BYTES_DEF = 1048576;
    localparam int HEADER_BYTES_DEF    = 48;
    localparam int MAX_EVICT_DEF       = 63;
    localparam int OWNER_BITS_DEF      = 16;

    localparam int CFG_W   = 21;
    localparam int WIDTH_W = 9;
    localparam int REQ_W   = 19;
    localparam int OWNER_W = 16;
    localparam int ADDR_W  = 20;
    localparam int BYTES_W = 21;
    localparam int NEED_W  = 20;

    localparam int MAX_BLOCK_WIDTH = 256;
    localparam int MAX_REQ         = 32'h10000 * 4;
    localparam int SPLIT_MIN       = 256;
    localparam int ARENA_GRAIN     = 8192;
    localparam int RESET_ARENA     = 1048576;

    typedef enum logic [1:0] {
        KIND_GRANT,
        KIND_EVICT,
        KIND_FLUSH,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_WIDTH,
        ERR_SIZE,
        ERR_ARENA,
        ERR_PAST_END,
        ERR_EVICT
    } err_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD,
        ST_EVAL,
        ST_COMMIT,
        ST_HEAD,
        ST_EV_RD,
        ST_EV_OUT,
        ST_GRANT
    } rba_state_t;

    typedef struct packed {
        logic      load;
        logic      flush;
        logic      init_walk;
        logic      accum;
        logic      advance;
        logic      commit;
        logic      head_wr;
        logic      ev_step;
        logic      emit;
        kind_t     emit_kind;
        err_code_t emit_code;
        logic      emit_last;
    } rba_cmd_t;

    typedef struct packed {
        logic      is_flush;
        logic      chk_err;
        err_code_t chk_code;
        logic      evict_over;
        logic      walk_done;
        logic      bad_step;
        logic      no_evict;
        logic      ev_last;
    } rba_stat_t;

    // usable arena: multiple of the grain, at least one grain, capped
    function automatic logic [31:0] eff_arena(input logic [CFG_W-1:0] v,
                                              input logic [31:0] max_bytes);
        logic [31:0] cap;
        logic [31:0] e;
        cap = max_bytes & ~32'(ARENA_GRAIN - 1);
        e   = 32'(v) & ~32'(ARENA_GRAIN - 1);
        if (e < 32'(ARENA_GRAIN))
            e = 32'(ARENA_GRAIN);
        if (e > cap)
            e = cap;
        return e;
    endfunction

endpackage

// ----- design/rba_ram.sv -----
module rba_ram
    import rba_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rba_ctrl.sv -----
module rba_ctrl
    import rba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  rba_stat_t stat,
    output rba_cmd_t  cmd
);

    rba_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.is_flush)
                begin
                    cmd.flush     = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_FLUSH;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (stat.chk_err)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ERROR;
                    cmd.emit_code = stat.chk_code;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.init_walk = 1'b1;
                    state_next    = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (stat.evict_over)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ERROR;
                    cmd.emit_code = ERR_EVICT;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.accum = 1'b1;
                    if (stat.walk_done)
                        state_next = ST_COMMIT;
                    else if (stat.bad_step)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_ERROR;
                        cmd.emit_code = ERR_PAST_END;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                cmd.head_wr = 1'b1;
                state_next  = stat.no_evict ? ST_GRANT : ST_EV_RD;
            end
            ST_EV_RD:
            begin
                state_next = ST_EV_OUT;
            end
            ST_EV_OUT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_EVICT;
                cmd.ev_step   = 1'b1;
                state_next    = stat.ev_last ? ST_GRANT : ST_EV_RD;
            end
            ST_GRANT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_GRANT;
                cmd.emit_last = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_walk_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |-> $past(state_reg) == ST_CHECK || $past(state_reg) == ST_EVAL)
        else $error("head read not preceded by check or walk step");
    a_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GRANT |=> state_reg == ST_IDLE)
        else $error("grant did not end the allocation");
    a_evout_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EV_OUT |-> $past(state_reg) == ST_EV_RD)
        else $error("evicted owner sent without a read");

endmodule

// ----- design/rba_dp.sv -----
module rba_dp
    import rba_pkg::*;
#(
    parameter int ARENA_MAX_BYTES = ARENA_MAX_BYTES_DEF,
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    parameter int MAX_EVICT       = MAX_EVICT_DEF,
    parameter int OWNER_BITS      = OWNER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               mode,
    input  logic [WIDTH_W-1:0] block_width,
    input  logic [REQ_W-1:0]   request_bytes,
    input  logic [OWNER_W-1:0] owner_id,
    input  rba_cmd_t           cmd,
    output rba_stat_t          stat,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [ADDR_W-1:0]  block_addr,
    output logic [BYTES_W-1:0] block_bytes,
    output logic [OWNER_W-1:0] evicted_owner,
    output logic [2:0]         error_code,
    output logic               last
);

    localparam int SW    = $clog2(ARENA_MAX_BYTES + 1);
    localparam int TW    = SW + 1;
    localparam int SLOTS = ARENA_MAX_BYTES / 4;
    localparam int IW    = $clog2(SLOTS);
    localparam int OB    = OWNER_BITS;
    localparam int HW    = WIDTH_W + OB + 1 + SW;
    localparam int CW    = $clog2(MAX_EVICT + 1);
    localparam int EAW   = (MAX_EVICT > 1) ? $clog2(MAX_EVICT) : 1;

    logic [CFG_W-1:0]   cfg_reg;
    logic [SW-1:0]      arena_reg;
    logic [SW-1:0]      rover_reg, rover_next;
    logic               fresh_reg;
    logic               mode_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [REQ_W-1:0]   req_reg;
    logic [OB-1:0]      owner_reg;
    logic [SW-1:0]      cur_reg, start_reg, gsize_reg;
    logic [TW-1:0]      total_reg;
    logic [CW-1:0]      nev_reg, k_reg;
    logic               rd_zero_reg;

    logic               res_valid_reg, last_reg;
    kind_t              kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [OWNER_W-1:0] eo_reg;
    err_code_t          code_reg;

    logic [31:0]   owner32, need32, arena32, ev32;
    logic [TW-1:0] need_t, tot_new, nxt, rem, frag;
    logic [SW-1:0] start_c, size_h;
    logic          valid_h, split;
    logic [OB-1:0] owner_h;
    logic [HW-1:0] head_rdata, head_wdata;
    logic [IW-1:0] head_waddr;
    logic          head_we;
    logic [OB-1:0] ev_rdata;

    assign owner32 = 32'(owner_id);
    assign need32  = (32'(req_reg) + 32'(HEADER_BYTES) + 32'd3) & ~32'd3;
    assign arena32 = 32'(arena_reg);
    assign need_t  = TW'(need32);

    // rover wraps to 0 if the block would not fit before the end
    assign start_c = (TW'(rover_reg) > TW'(arena_reg) - need_t) ? '0 : rover_reg;

    // head as read; entry 0 after reset or flush is one free block
    assign size_h  = (fresh_reg && rd_zero_reg) ? arena_reg : head_rdata[SW-1:0];
    assign valid_h = (fresh_reg && rd_zero_reg) ? 1'b0 : head_rdata[SW];
    assign owner_h = head_rdata[SW+OB:SW+1];

    assign tot_new = total_reg + TW'(size_h);
    assign nxt     = TW'(cur_reg) + TW'(size_h);

    // input checks and walk status
    always_comb
    begin
        stat.is_flush = mode_reg;
        stat.chk_err  = 1'b1;
        stat.chk_code = ERR_WIDTH;
        if (width_reg > WIDTH_W'(MAX_BLOCK_WIDTH))
            stat.chk_code = ERR_WIDTH;
        else if (req_reg == '0 || 32'(req_reg) > 32'(MAX_REQ))
            stat.chk_code = ERR_SIZE;
        else if (need32 > arena32)
            stat.chk_code = ERR_ARENA;
        else
            stat.chk_err = 1'b0;
        stat.walk_done  = (tot_new >= need_t);
        stat.bad_step   = (size_h == '0) || (nxt >= TW'(arena_reg));
        stat.evict_over = valid_h && (nev_reg == CW'(MAX_EVICT));
        stat.no_evict   = (nev_reg == '0);
        stat.ev_last    = ((k_reg + CW'(1)) == nev_reg);
    end

    assign rem   = total_reg - need_t;
    assign split = (rem > TW'(SPLIT_MIN));
    assign frag  = TW'(start_reg) + need_t;

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = start_reg[IW+1:2];
        head_wdata = {width_reg, owner_reg, 1'b1, gsize_reg};
        if (cmd.commit)
        begin
            head_we    = split;
            head_waddr = frag[IW+1:2];
            head_wdata = {{WIDTH_W{1'b0}}, {OB{1'b0}}, 1'b0, SW'(rem)};
        end
        else if (cmd.head_wr)
            head_we = 1'b1;
    end

    assign rover_next = split ? SW'(frag) : SW'(TW'(start_reg) + total_reg);

    rba_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (cur_reg[IW+1:2]),
        .rdata (head_rdata)
    );

    // evicted owners are held until the walk is known to succeed
    rba_ram #(.WIDTH(OB), .DEPTH(MAX_EVICT)) u_ev_ram (
        .clk   (clk),
        .we    (cmd.accum && valid_h),
        .waddr (nev_reg[EAW-1:0]),
        .wdata (owner_h),
        .raddr (k_reg[EAW-1:0]),
        .rdata (ev_rdata)
    );

    assign ev32 = 32'(ev_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_W'(RESET_ARENA);
            arena_reg     <= SW'(eff_arena(CFG_W'(RESET_ARENA), 32'(ARENA_MAX_BYTES)));
            rover_reg     <= '0;
            fresh_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cfg_reg <= cfg_wr_data;
            if (cmd.flush)
            begin
                arena_reg <= SW'(eff_arena(cfg_reg, 32'(ARENA_MAX_BYTES)));
                rover_reg <= '0;
                fresh_reg <= 1'b1;
            end
            if (cmd.commit)
                rover_reg <= rover_next;
            if (cmd.head_wr && start_reg[IW+1:2] == '0)
                fresh_reg <= 1'b0;
            res_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_zero_reg <= (cur_reg[IW+1:2] == '0);
        if (cmd.load)
        begin
            mode_reg  <= mode;
            width_reg <= block_width;
            req_reg   <= request_bytes;
            owner_reg <= owner32[OB-1:0];
        end
        if (cmd.init_walk)
        begin
            start_reg <= start_c;
            cur_reg   <= start_c;
            total_reg <= '0;
            nev_reg   <= '0;
            k_reg     <= '0;
        end
        if (cmd.accum)
        begin
            total_reg <= tot_new;
            if (valid_h)
                nev_reg <= nev_reg + CW'(1);
        end
        if (cmd.advance)
            cur_reg <= SW'(nxt);
        if (cmd.commit)
            gsize_reg <= split ? SW'(need_t) : SW'(total_reg);
        if (cmd.ev_step)
            k_reg <= k_reg + CW'(1);
        if (cmd.emit)
        begin
            kind_reg  <= cmd.emit_kind;
            last_reg  <= cmd.emit_last;
            code_reg  <= (cmd.emit_kind == KIND_ERROR) ? cmd.emit_code : ERR_WIDTH;
            addr_reg  <= (cmd.emit_kind == KIND_GRANT) ? ADDR_W'(start_reg) : '0;
            bytes_reg <= (cmd.emit_kind == KIND_GRANT) ? BYTES_W'(gsize_reg) : '0;
            eo_reg    <= (cmd.emit_kind == KIND_EVICT) ? ev32[OWNER_W-1:0] : '0;
        end
    end

    assign result_valid  = res_valid_reg;
    assign kind          = kind_reg;
    assign block_addr    = addr_reg;
    assign block_bytes   = bytes_reg;
    assign evicted_owner = eo_reg;
    assign error_code    = code_reg;
    assign last          = last_reg;

endmodule

// ----- design/rover_block_allocator_unit.sv -----
// Rover ring block allocator.
// Input channel: present mode, block_width, request_bytes and owner_id with
// start high; the word is taken at a clock edge where busy is low. busy
// stays high until the last result of that word has been issued.
// Result channel: each result word sits on kind/block_addr/block_bytes/
// evicted_owner/error_code/last for one cycle with result_valid high. The
// receiver cannot stall; it must take every word as it appears. last marks
// the final word of an input. An allocation sends one evicted-owner word per
// reclaimed block that had an owner, then the grant.
// Sequence: every input passes through the check state after the accepting
// edge; a flush or check error is issued there and registered onto the
// ports. An allocation then reads each block head it visits from the head
// memory (registered data) and evaluates it, then commits, writes the head,
// sends each evicted owner after a read of the owner memory, then the grant;
// a walk error ends at the head where it is found. busy blocks new input.
// Config: cfg_wr_en/cfg_wr_data write arena_bytes; the live arena size is
// picked up only at reset and at flush.
// Reset: rover at 0, arena is one free block of the reset size; no memory
// clearing pass is needed, entry 0 is supplied by a flag until rewritten.
module rover_block_allocator_unit
    import rba_pkg::*;
#(
    parameter int ARENA_MAX_BYTES = ARENA_MAX_BYTES_DEF,
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    parameter int MAX_EVICT       = MAX_EVICT_DEF,
    parameter int OWNER_BITS      = OWNER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [WIDTH_W-1:0] block_width,
    input  logic [REQ_W-1:0]   request_bytes,
    input  logic [OWNER_W-1:0] owner_id,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [ADDR_W-1:0]  block_addr,
    output logic [BYTES_W-1:0] block_bytes,
    output logic [OWNER_W-1:0] evicted_owner,
    output logic [2:0]         error_code,
    output logic               last
);

    rba_cmd_t  cmd;
    rba_stat_t stat;

    rba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    rba_dp #(
        .ARENA_MAX_BYTES (ARENA_MAX_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .MAX_EVICT       (MAX_EVICT),
        .OWNER_BITS      (OWNER_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mode          (mode),
        .block_width   (block_width),
        .request_bytes (request_bytes),
        .owner_id      (owner_id),
        .cmd           (cmd),
        .stat          (stat),
        .result_valid  (result_valid),
        .kind          (kind),
        .block_addr    (block_addr),
        .block_bytes   (block_bytes),
        .evicted_owner (evicted_owner),
        .error_code    (error_code),
        .last          (last)
    );

    // the final word of an input always finds the unit free again
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("last word issued while still busy");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");
    a_only_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> kind == KIND_EVICT)
        else $error("non-final word that is not an evicted owner");
    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_ERROR |-> last && !$past(result_valid))
        else $error("error word not the only word of its input");

endmodule

// ----- dv/rba_checker.sv -----
`timescale 1ns / 100ps

// Watches the command and result channels of the allocator, keeps its own
// copy of the block chain and checks every result word in order.
module rba_checker
    import rba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               start,
    input  logic               busy,
    input  logic               mode,
    input  logic [WIDTH_W-1:0] block_width,
    input  logic [REQ_W-1:0]   request_bytes,
    input  logic [OWNER_W-1:0] owner_id,
    input  logic               result_valid,
    input  logic [1:0]         kind,
    input  logic [ADDR_W-1:0]  block_addr,
    input  logic [BYTES_W-1:0] block_bytes,
    input  logic [OWNER_W-1:0] evicted_owner,
    input  logic [2:0]         error_code,
    input  logic               last,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        kind_t              k;
        bit [ADDR_W-1:0]    addr;
        bit [BYTES_W-1:0]   bytes;
        bit [OWNER_W-1:0]   owner;
        err_code_t          code;
        bit                 lst;
    } alloc_word_t;

    alloc_word_t      words_due[$];

    bit [CFG_W-1:0]   arena_reg;
    longint unsigned  arena_now;
    longint unsigned  rover;
    bit [BYTES_W-1:0] blk_size[int unsigned];
    bit               blk_owned[int unsigned];
    bit [OWNER_W-1:0] blk_owner[int unsigned];

    // register value -> usable size: whole 8 KiB grains, at least one, capped
    function automatic longint unsigned arena_fit(bit [CFG_W-1:0] v);
        longint unsigned grains;
        grains = v / ARENA_GRAIN;
        if (grains == 0)
            grains = 1;
        if (grains * ARENA_GRAIN > ARENA_MAX_BYTES_DEF)
            grains = ARENA_MAX_BYTES_DEF / ARENA_GRAIN;
        return grains * ARENA_GRAIN;
    endfunction

    function automatic longint unsigned size_at(longint unsigned a);
        return blk_size.exists(a >> 2) ? blk_size[a >> 2] : 0;
    endfunction

    function automatic bit owned_at(longint unsigned a);
        return blk_owned.exists(a >> 2) ? blk_owned[a >> 2] : 1'b0;
    endfunction

    function automatic void push_word(kind_t k, longint unsigned addr,
                                      longint unsigned bytes, bit [OWNER_W-1:0] own,
                                      err_code_t code, bit lst);
        alloc_word_t w;
        w.k     = k;
        w.addr  = addr[ADDR_W-1:0];
        w.bytes = bytes[BYTES_W-1:0];
        w.owner = own;
        w.code  = code;
        w.lst   = lst;
        words_due.push_back(w);
    endfunction

    function automatic void wipe_arena();
        arena_now    = arena_fit(arena_reg);
        rover        = 0;
        blk_size[0]  = arena_now[BYTES_W-1:0];
        blk_owned[0] = 1'b0;
    endfunction

    // one accepted command word -> expected result words; state changes only
    // on a flush or when the allocation succeeds
    function automatic void allocate(bit m, bit [WIDTH_W-1:0] w,
                                     bit [REQ_W-1:0] req, bit [OWNER_W-1:0] own);
        longint unsigned need, base, cur, total, step, gsize, frag;
        bit [OWNER_W-1:0] victims[$];
        bit               failed;
        err_code_t        why;
        failed = 1'b0;
        why    = ERR_WIDTH;
        if (m) begin
            wipe_arena();
            push_word(KIND_FLUSH, 0, 0, '0, ERR_WIDTH, 1'b1);
            return;
        end
        need = (longint'(req) + HEADER_BYTES_DEF + 3) & ~longint'(3);
        if (w > MAX_BLOCK_WIDTH) begin
            failed = 1'b1;
            why    = ERR_WIDTH;
        end else if (req == 0 || req > MAX_REQ) begin
            failed = 1'b1;
            why    = ERR_SIZE;
        end else if (need > arena_now) begin
            failed = 1'b1;
            why    = ERR_ARENA;
        end
        if (failed) begin
            push_word(KIND_ERROR, 0, 0, '0, why, 1'b1);
            return;
        end
        base = (rover > arena_now - need) ? 0 : rover;
        cur  = base;
        if (owned_at(cur))
            victims.push_back(blk_owner[cur >> 2]);
        total = size_at(cur);
        while (total < need && !failed) begin
            step = size_at(cur);
            if (step == 0 || cur + step >= arena_now) begin
                failed = 1'b1;
                why    = ERR_PAST_END;
            end else begin
                cur = cur + step;
                if (owned_at(cur)) begin
                    if (victims.size() >= MAX_EVICT_DEF) begin
                        failed = 1'b1;
                        why    = ERR_EVICT;
                    end else
                        victims.push_back(blk_owner[cur >> 2]);
                end
                total += size_at(cur);
            end
        end
        if (failed) begin
            push_word(KIND_ERROR, 0, 0, '0, why, 1'b1);
            return;
        end
        if (total - need > SPLIT_MIN) begin
            frag                 = base + need;
            blk_size[frag >> 2]  = BYTES_W'(total - need);
            blk_owned[frag >> 2] = 1'b0;
            blk_owner[frag >> 2] = '0;
            rover                = frag;
            gsize                = need;
        end else begin
            rover = base + total;
            gsize = total;
        end
        blk_size[base >> 2]  = gsize[BYTES_W-1:0];
        blk_owned[base >> 2] = 1'b1;
        blk_owner[base >> 2] = own;
        foreach (victims[i])
            push_word(KIND_EVICT, 0, 0, victims[i], ERR_WIDTH, 1'b0);
        push_word(KIND_GRANT, base, gsize, '0, ERR_WIDTH, 1'b1);
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        arena_reg  = CFG_W'(RESET_ARENA);
        wipe_arena();
    end

    always @(posedge clk)
    begin
        alloc_word_t due;
        if (rst_n) begin
            if (result_valid) begin
                if (words_due.size() == 0) begin
                    $error("result word with nothing expected: kind %0d", kind);
                    fail_count++;
                end else begin
                    due = words_due.pop_front();
                    if (kind !== due.k) begin
                        $error("kind: expected %0d actual %0d", due.k, kind);
                        fail_count++;
                    end
                    if (block_addr !== due.addr) begin
                        $error("block_addr: expected %0h actual %0h", due.addr, block_addr);
                        fail_count++;
                    end
                    if (block_bytes !== due.bytes) begin
                        $error("block_bytes: expected %0d actual %0d", due.bytes, block_bytes);
                        fail_count++;
                    end
                    if (evicted_owner !== due.owner) begin
                        $error("evicted_owner: expected %0h actual %0h",
                               due.owner, evicted_owner);
                        fail_count++;
                    end
                    if (error_code !== due.code) begin
                        $error("error_code: expected %0d actual %0d", due.code, error_code);
                        fail_count++;
                    end
                    if (last !== due.lst) begin
                        $error("last: expected %0d actual %0d", due.lst, last);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
                arena_reg = cfg_wr_data;
            if (start && !busy)
                allocate(mode, block_width, request_bytes, owner_id);
            pending = words_due.size();
        end
    end

endmodule

// ----- dv/tb_rover_block_allocator_unit.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the rover allocator. The checker beside the DUT
// does all prediction; this module only drives command words and config.
module tb_rover_block_allocator_unit;
    import rba_pkg::*;

    localparam int RUN_LIMIT = 1000000;   // cycles, far above the slowest run

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CFG_W-1:0]   cfg_wr_data;
    logic               start;
    logic               busy;
    logic               mode;
    logic [WIDTH_W-1:0] block_width;
    logic [REQ_W-1:0]   request_bytes;
    logic [OWNER_W-1:0] owner_id;
    logic               result_valid;
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  block_addr;
    logic [BYTES_W-1:0] block_bytes;
    logic [OWNER_W-1:0] evicted_owner;
    logic [2:0]         error_code;
    logic               last;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 idle_pct;

    rover_block_allocator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .block_width   (block_width),
        .request_bytes (request_bytes),
        .owner_id      (owner_id),
        .result_valid  (result_valid),
        .kind          (kind),
        .block_addr    (block_addr),
        .block_bytes   (block_bytes),
        .evicted_owner (evicted_owner),
        .error_code    (error_code),
        .last          (last)
    );

    rba_checker i_chk (.*);

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One command word. Inputs move only at the falling edge; the word is
    // taken at the next rising edge that sees busy low.
    task automatic send_word(bit m, bit [WIDTH_W-1:0] w, bit [REQ_W-1:0] r,
                             bit [OWNER_W-1:0] o);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap   = $urandom_range(1, 8);
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         = 1'b1;
        mode          = m;
        block_width   = w;
        request_bytes = r;
        owner_id      = o;
        while (busy)
            @(negedge clk);
        // busy is low through this low phase, so the coming edge takes it
        @(negedge clk);
        start = 1'b0;
    endtask

    // Drain: every expected word back, then a margin before anything touches
    // the config register.
    task automatic drain();
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_arena(bit [CFG_W-1:0] v);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic alloc_word(bit [WIDTH_W-1:0] w, bit [REQ_W-1:0] r);
        send_word(1'b0, w, r, 16'($urandom));
    endtask

    // Mostly well-formed allocations with a bias toward tiny blocks, so small
    // arenas wrap often and big requests sweep long runs of owned blocks
    // (that is the only way to reach the eviction limit). About one word in
    // eight is noise: bad width, bad size, or a flush out of the blue.
    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            alloc_word(9'($urandom_range(0, MAX_BLOCK_WIDTH)), 19'($urandom_range(1, 16)));
        else if (pick < 70)
            alloc_word(9'($urandom_range(0, MAX_BLOCK_WIDTH)), 19'($urandom_range(1, 512)));
        else if (pick < 80)
            alloc_word(9'($urandom_range(0, MAX_BLOCK_WIDTH)), 19'($urandom_range(1, 8192)));
        else if (pick < 88)
            alloc_word(9'($urandom_range(0, MAX_BLOCK_WIDTH)),
                       19'($urandom_range(1, MAX_REQ)));
        else if (pick < 92)
            alloc_word(9'($urandom_range(MAX_BLOCK_WIDTH + 1, 511)),
                       19'($urandom_range(0, 524287)));
        else if (pick < 98)
            alloc_word(9'($urandom_range(0, 511)), 19'($urandom_range(0, 524287)));
        else
            send_word(1'b1, 9'($urandom), 19'($urandom), 16'($urandom));
    endtask

    initial
    begin
        bit [CFG_W-1:0] arena_plan[7];
        cycles        = 0;
        idle_pct      = 0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        start         = 1'b0;
        mode          = 1'b0;
        block_width   = '0;
        request_bytes = '0;
        owner_id      = '0;
        arena_plan    = '{21'd8192, 21'd0, 21'd1048576, 21'h1FFFFF,
                          21'd24576, 21'd100000, 21'd8192};
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // --- directed: field extremes, width and size checks, reset-size arena ---
        send_word(1'b0, 9'd0, 19'd1, 16'h0000);
        send_word(1'b0, 9'd256, 19'd262144, 16'hFFFF);   // largest legal
        send_word(1'b0, 9'd257, 19'd100, 16'h1234);      // width just over
        send_word(1'b0, 9'd511, 19'd100, 16'h1234);
        send_word(1'b0, 9'd10, 19'd0, 16'h5555);         // zero size
        send_word(1'b0, 9'd10, 19'd262145, 16'hAAAA);    // size just over
        send_word(1'b0, 9'd10, 19'd524287, 16'hAAAA);
        send_word(1'b1, 9'd511, 19'd524287, 16'hFFFF);   // flush, junk payload

        // --- directed: smallest arena, exact fits, wrap and eviction ---
        write_arena(21'd8192);
        send_word(1'b1, 9'd0, 19'd0, 16'h0000);
        send_word(1'b0, 9'd1, 19'd262144, 16'h0001);     // exceeds arena
        send_word(1'b0, 9'd1, 19'd8144, 16'h0002);       // whole arena, no split
        send_word(1'b0, 9'd2, 19'd1000, 16'h0003);       // rover at end -> wrap
        send_word(1'b0, 9'd3, 19'd7000, 16'h0004);       // leftover under split
        send_word(1'b0, 9'd4, 19'd100, 16'h0005);
        send_word(1'b0, 9'd5, 19'd3, 16'h0006);          // rounding
        send_word(1'b0, 9'd6, 19'd8144, 16'h0007);       // sweeps owned blocks
        send_word(1'b1, 9'd0, 19'd0, 16'h0000);
        for (int i = 0; i < 70; i++)                     // build a long owned run
            send_word(1'b0, 9'(i), 19'd1, 16'(16'h100 + i));
        send_word(1'b0, 9'd7, 19'd8144, 16'h0008);       // too many evictions

        // --- random phases, one arena setting each, sender idling varies ---
        foreach (arena_plan[p])
        begin
            write_arena(arena_plan[p]);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 70;
                default: idle_pct = 6;
            endcase
            send_word(1'b1, 9'd0, 19'd0, 16'd0);
            for (int n = 0; n < 41; n++) begin
                random_word();
                // in the third phase, hold off once mid-phase until the pipe is empty
                if (p == 2 && n == 20)
                    while (pending != 0 || busy)
                        @(negedge clk);
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
design/rba_pkg.sv
design/rba_ram.sv
design/rba_ctrl.sv
design/rba_dp.sv
design/rover_block_allocator_unit.sv
dv/rba_checker.sv
dv/tb_rover_block_allocator_unit.sv
